// ----- sv/hmte_pkg.sv -----
// Shared types and constants for the hash map table engine.
package hmte_pkg;

   localparam int KeyW = 32;
   localparam int ValW = 32;
   // One slot in a bucket row: {valid, key, value}, value in the low bits.
   localparam int SlotW = KeyW + ValW + 1;

   typedef enum logic [1:0] {
      CMD_LOOKUP  = 2'd0,
      CMD_INSERT  = 2'd1,
      CMD_REPLACE = 2'd2,
      CMD_REMOVE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OUT_NEW     = 2'd0,
      OUT_PRESENT = 2'd1,
      OUT_ABSENT  = 2'd2,
      OUT_FULL    = 2'd3
   } outcome_type;

endpackage

// ----- sv/hmte_ram.sv -----
// Generic RAM with one write port and one registered read port.
module hmte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/hash_map_table_engine.sv -----
// Hash map table engine: bucketed key/value table with lookup, insert, replace, remove.
// Throughput: one request word per cycle while the response channel is not stalled; each
// word reads one bucket row from the table RAM and writes it back only when it changes
// it, with the last written row forwarded to the next word.
// Reset: synchronous, active high; afterwards a clearing pass writes every bucket row
// empty, one row a cycle, with req_tready held low.
module hash_map_table_engine #(
   parameter int BUCKETS = 128,
   parameter int WAYS    = 4
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] key, [63:32] value
   input  logic [1:0]  req_tuser,   // [1:0] command
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] found_value
   output logic [1:0]  rsp_tuser    // [1:0] outcome
);

   localparam int KeyW  = hmte_pkg::KeyW;
   localparam int ValW  = hmte_pkg::ValW;
   localparam int SlotW = hmte_pkg::SlotW;
   localparam int RowW  = WAYS * SlotW;
   localparam int BW    = $clog2(BUCKETS);

   // The bucket is key mod BUCKETS. The quotient is estimated with a reciprocal
   // multiply that is exact or one too small, so one conditional subtract of
   // BUCKETS finishes the remainder.
   localparam int          Shift     = KeyW + $clog2(BUCKETS) - 1;
   localparam int          QW        = 2 * KeyW - Shift;
   localparam logic [63:0] RecipWide = (64'd1 << Shift) / 64'(BUCKETS);
   localparam logic [KeyW-1:0] RecipMul  = RecipWide[KeyW-1:0];
   localparam logic [KeyW-1:0] BucketsK  = KeyW'(BUCKETS);
   localparam logic [BW-1:0]   LastRow   = BW'(BUCKETS - 1);

   // Stage enables: a stage moves when it is empty or the one after it moves.
   logic out_en, x_en, h3_en, h2_en, h1_en;

   // Stage h1: accepted request word.
   logic                 h1_vld_ff;
   hmte_pkg::cmd_type    h1_cmd_ff;
   logic [KeyW-1:0]      h1_key_ff;
   logic [ValW-1:0]      h1_val_ff;
   logic [2*KeyW-1:0]    h1_prod;

   // Stage h2: quotient estimate.
   logic                 h2_vld_ff;
   hmte_pkg::cmd_type    h2_cmd_ff;
   logic [KeyW-1:0]      h2_key_ff;
   logic [ValW-1:0]      h2_val_ff;
   logic [QW-1:0]        h2_q_ff;
   logic [QW-1:0]        h2_q_in;
   logic [KeyW-1:0]      h2_qb;

   // Stage h3: quotient times BUCKETS; the remainder addresses the table.
   logic                 h3_vld_ff;
   hmte_pkg::cmd_type    h3_cmd_ff;
   logic [KeyW-1:0]      h3_key_ff;
   logic [ValW-1:0]      h3_val_ff;
   logic [KeyW-1:0]      h3_qb_ff;
   logic [KeyW-1:0]      h3_rem;
   logic [KeyW-1:0]      h3_rem_adj;
   logic [BW-1:0]        h3_bucket;

   // Stage x: bucket row arrives from the RAM; compare, update, write back.
   logic                 x_vld_ff;
   hmte_pkg::cmd_type    x_cmd_ff;
   logic [KeyW-1:0]      x_key_ff;
   logic [ValW-1:0]      x_val_ff;
   logic [BW-1:0]        x_bucket_ff;
   logic                 x_fire;
   logic [RowW-1:0]      x_row;
   logic [RowW-1:0]      x_row_in;
   logic [WAYS-1:0]      match_vec;
   logic [WAYS-1:0]      free_vec;
   logic [WAYS-1:0]      hit_oh;
   logic [WAYS-1:0]      free_oh;
   logic                 hit_any;
   logic                 free_any;
   logic [ValW-1:0]      hit_val;
   hmte_pkg::outcome_type x_outcome;
   logic [ValW-1:0]      x_found;
   logic                 item_wr_en;

   // Forwarding copy of the last row written by a request.
   logic                 fwd_vld_ff;
   logic [BW-1:0]        fwd_addr_ff;
   logic [RowW-1:0]      fwd_row_ff;

   // Response register.
   logic                  out_vld_ff;
   hmte_pkg::outcome_type out_outcome_ff;
   logic [ValW-1:0]       out_found_ff;

   // Clearing pass after reset.
   logic                 clr_busy_ff;
   logic [BW-1:0]        clr_addr_ff;

   // RAM ports.
   logic                 ram_wr_en;
   logic [BW-1:0]        ram_wr_addr;
   logic [RowW-1:0]      ram_wr_data;
   logic                 ram_rd_en;
   logic [RowW-1:0]      ram_rd_data;

   assign out_en = !out_vld_ff || rsp_tready;
   assign x_en   = !x_vld_ff   || out_en;
   assign h3_en  = !h3_vld_ff  || x_en;
   assign h2_en  = !h2_vld_ff  || h3_en;
   assign h1_en  = !h1_vld_ff  || h2_en;

   assign req_tready = h1_en && !clr_busy_ff;

   // Hash arithmetic.
   assign h1_prod    = (2*KeyW)'(h1_key_ff) * (2*KeyW)'(RecipMul);
   assign h2_q_in    = h1_prod[2*KeyW-1:Shift];
   assign h2_qb      = KeyW'(KeyW'(h2_q_ff) * BucketsK);
   assign h3_rem     = h3_key_ff - h3_qb_ff;
   assign h3_rem_adj = (h3_rem >= BucketsK) ? (h3_rem - BucketsK) : h3_rem;
   assign h3_bucket  = h3_rem_adj[BW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_vld_ff <= 1'b0;
         h2_vld_ff <= 1'b0;
         h3_vld_ff <= 1'b0;
         x_vld_ff  <= 1'b0;
      end else begin
         if (h1_en) begin
            h1_vld_ff <= req_tvalid && req_tready;
         end
         if (h2_en) begin
            h2_vld_ff <= h1_vld_ff;
         end
         if (h3_en) begin
            h3_vld_ff <= h2_vld_ff;
         end
         if (x_en) begin
            x_vld_ff <= h3_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (h1_en) begin
         h1_cmd_ff <= hmte_pkg::cmd_type'(req_tuser);
         h1_key_ff <= req_tdata[KeyW-1:0];
         h1_val_ff <= req_tdata[KeyW+ValW-1:KeyW];
      end
      if (h2_en) begin
         h2_cmd_ff <= h1_cmd_ff;
         h2_key_ff <= h1_key_ff;
         h2_val_ff <= h1_val_ff;
         h2_q_ff   <= h2_q_in;
      end
      if (h3_en) begin
         h3_cmd_ff <= h2_cmd_ff;
         h3_key_ff <= h2_key_ff;
         h3_val_ff <= h2_val_ff;
         h3_qb_ff  <= h2_qb;
      end
      if (x_en) begin
         x_cmd_ff    <= h3_cmd_ff;
         x_key_ff    <= h3_key_ff;
         x_val_ff    <= h3_val_ff;
         x_bucket_ff <= h3_bucket;
      end
   end

   // The RAM output only moves when a request enters stage x, so it stays
   // valid while stage x is stalled.
   assign ram_rd_en = h3_vld_ff && x_en;

   // The row read for stage x misses the write made in the same cycle by the
   // request ahead of it; the forwarding copy always holds the newest row
   // written, so on an address match it is the current bucket contents.
   assign x_row = (fwd_vld_ff && (fwd_addr_ff == x_bucket_ff)) ? fwd_row_ff : ram_rd_data;

   // Compare all ways at once and pick the lowest hit and the lowest free way.
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         free_vec[w]  = !x_row[w*SlotW + SlotW - 1];
         match_vec[w] = x_row[w*SlotW + SlotW - 1] &&
                        (x_row[w*SlotW + ValW +: KeyW] == x_key_ff);
      end
   end

   assign hit_oh   = match_vec & (~match_vec + WAYS'(1));
   assign free_oh  = free_vec & (~free_vec + WAYS'(1));
   assign hit_any  = |match_vec;
   assign free_any = |free_vec;

   always_comb begin
      hit_val = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (hit_oh[w]) begin
            hit_val = hit_val | x_row[w*SlotW +: ValW];
         end
      end
   end

   always_comb begin
      x_row_in   = x_row;
      x_outcome  = hmte_pkg::OUT_ABSENT;
      x_found    = '0;
      item_wr_en = 1'b0;
      unique case (x_cmd_ff) inside
         hmte_pkg::CMD_LOOKUP: begin
            if (hit_any) begin
               x_outcome = hmte_pkg::OUT_PRESENT;
               x_found   = hit_val;
            end
         end
         hmte_pkg::CMD_REMOVE: begin
            if (hit_any) begin
               x_outcome  = hmte_pkg::OUT_PRESENT;
               item_wr_en = 1'b1;
               for (int w = 0; w < WAYS; w++) begin
                  if (hit_oh[w]) begin
                     x_row_in[w*SlotW + SlotW - 1] = 1'b0;
                  end
               end
            end
         end
         hmte_pkg::CMD_INSERT, hmte_pkg::CMD_REPLACE: begin
            if (hit_any) begin
               x_outcome = hmte_pkg::OUT_PRESENT;
               if (x_cmd_ff == hmte_pkg::CMD_REPLACE) begin
                  item_wr_en = 1'b1;
                  for (int w = 0; w < WAYS; w++) begin
                     if (hit_oh[w]) begin
                        x_row_in[w*SlotW +: ValW] = x_val_ff;
                     end
                  end
               end
            end else if (free_any) begin
               x_outcome  = hmte_pkg::OUT_NEW;
               item_wr_en = 1'b1;
               for (int w = 0; w < WAYS; w++) begin
                  if (free_oh[w]) begin
                     x_row_in[w*SlotW +: SlotW] = {1'b1, x_key_ff, x_val_ff};
                  end
               end
            end else begin
               x_outcome = hmte_pkg::OUT_FULL;
            end
         end
      endcase
   end

   assign x_fire = x_vld_ff && out_en;

   // Write port: the clearing pass owns it until done; no request is in
   // flight then.
   always_comb begin
      if (clr_busy_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = x_fire && item_wr_en;
         ram_wr_addr = x_bucket_ff;
         ram_wr_data = x_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == LastRow) begin
            clr_busy_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + BW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_vld_ff <= 1'b0;
      end else if (x_fire && item_wr_en) begin
         fwd_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (x_fire && item_wr_en) begin
         fwd_addr_ff <= x_bucket_ff;
         fwd_row_ff  <= x_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_en) begin
         out_vld_ff <= x_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (x_fire) begin
         out_outcome_ff <= x_outcome;
         out_found_ff   <= x_found;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_found_ff;
   assign rsp_tuser  = out_outcome_ff;

   hmte_ram #(
      .WIDTH (RowW),
      .DEPTH (BUCKETS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (h3_bucket),
      .rd_data (ram_rd_data)
   );

   // A key is stored at most once in its bucket.
   a_unique_key: assert property (@(posedge clock) disable iff (reset)
      x_vld_ff |-> $onehot0(match_vec))
      else $error("duplicate key in bucket");

   // Only a lookup returns a nonzero value.
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      (x_fire && (x_cmd_ff != hmte_pkg::CMD_LOOKUP)) |=> (rsp_tdata == '0))
      else $error("found_value set on a non-lookup word");

   // A full bucket leaves the table unchanged.
   a_full_no_write: assert property (@(posedge clock) disable iff (reset)
      (x_fire && (x_outcome == hmte_pkg::OUT_FULL)) |-> !item_wr_en)
      else $error("write on a full bucket");

   // No response appears while the table is being cleared.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> (!rsp_tvalid && !x_vld_ff))
      else $error("request in flight during the clearing pass");

endmodule

// ----- verif/hash_map_table_engine_tb.sv -----
// Self-checking testbench for the hash map table engine with a built-in table predictor.
`timescale 1ns / 100ps

module hash_map_table_engine_tb;

   // The block is built with its default geometry, so the predictor mirrors it.
   localparam int BUCKETS = 128;
   localparam int WAYS = 4;
   localparam int SLOTS = BUCKETS * WAYS;
   localparam int POOL_SIZE = 40;
   // The limit lies well above what the slowest correct run needs, leaving a wide margin.
   localparam int CYCLE_LIMIT = 200000;

   // One response word as the predictor expects it.
   typedef struct packed {
      hmte_pkg::outcome_type outcome;
      logic [31:0] found_value;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;    // [31:0] key, [63:32] value
   logic [1:0]  req_tuser = '0;    // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] found_value
   logic [1:0]  rsp_tuser;         // [1:0] outcome

   // Predictor copy of the slot store, indexed by bucket * WAYS + way.
   logic        map_valid [SLOTS];
   logic [31:0] map_key [SLOTS];
   logic [31:0] map_value [SLOTS];

   // Replies predicted for accepted request words, oldest first.
   reply_type   awaited_replies [$];

   // Keys used by the random phases; they crowd a few buckets so that hits,
   // full buckets and freed ways all come up often.
   logic [31:0] key_pool [POOL_SIZE];

   int          mismatch_count = 0;
   int          cycle_count = 0;
   // When set, the sender or the receiver runs without idle cycles.
   bit          sender_steady = 1'b0;
   bit          receiver_steady = 1'b0;
   // A nonzero value asks the receiver process to hold off for that many cycles.
   int          hold_off_cycles = 0;

   hash_map_table_engine #(
      .BUCKETS(BUCKETS),
      .WAYS(WAYS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #2 clock = ~clock;

   // Applies one request to the predicted table and returns the reply it causes.
   // The bucket is the key read as unsigned, modulo BUCKETS; all ways of the
   // bucket are compared on the full 32 bits of the key.
   function automatic reply_type map_access(hmte_pkg::cmd_type cmd, logic [31:0] key,
                                            logic [31:0] val);
      reply_type reply;
      int base;
      int hit;
      int free_way;
      base = int'(key % BUCKETS) * WAYS;
      hit = -1;
      free_way = -1;
      reply.outcome = hmte_pkg::OUT_ABSENT;
      reply.found_value = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (map_valid[base + w]) begin
            if (hit < 0 && map_key[base + w] == key) hit = w;
         end else if (free_way < 0) begin
            free_way = w;
         end
      end
      case (cmd) inside
         hmte_pkg::CMD_LOOKUP: begin
            if (hit >= 0) begin
               reply.outcome = hmte_pkg::OUT_PRESENT;
               reply.found_value = map_value[base + hit];
            end
         end
         hmte_pkg::CMD_REMOVE: begin
            if (hit >= 0) begin
               map_valid[base + hit] = 1'b0;
               reply.outcome = hmte_pkg::OUT_PRESENT;
            end
         end
         hmte_pkg::CMD_INSERT, hmte_pkg::CMD_REPLACE: begin
            // Insert keeps a present entry; replace overwrites its value.
            if (hit >= 0) begin
               if (cmd == hmte_pkg::CMD_REPLACE) map_value[base + hit] = val;
               reply.outcome = hmte_pkg::OUT_PRESENT;
            end else if (free_way >= 0) begin
               map_valid[base + free_way] = 1'b1;
               map_key[base + free_way] = key;
               map_value[base + free_way] = val;
               reply.outcome = hmte_pkg::OUT_NEW;
            end else begin
               reply.outcome = hmte_pkg::OUT_FULL;
            end
         end
      endcase
      return reply;
   endfunction

   // Prints one line for a mismatch and counts it.
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Sends one request word and predicts its reply once it is accepted.
   // Valid is left high after the handshake so that a following word with no
   // gap keeps it high; it is lowered only before a gap or a pause.
   task automatic send_request(hmte_pkg::cmd_type cmd, logic [31:0] key, logic [31:0] val);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {val, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      awaited_replies.push_back(map_access(cmd, key, val));
   endtask

   // Stops offering words and waits until every predicted reply has come back.
   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   // Fills the key pool: random upper bits, with the bucket bits drawn from a
   // handful of buckets so that each one overflows its ways now and then.
   task automatic refill_key_pool(int bucket_count);
      logic [6:0] buckets [8];
      for (int b = 0; b < 8; b++) buckets[b] = 7'($urandom_range(0, BUCKETS - 1));
      for (int k = 0; k < POOL_SIZE; k++) begin
         key_pool[k] = $urandom;
         key_pool[k][6:0] = buckets[$urandom_range(0, bucket_count - 1)];
      end
   endtask

   // Sends one random request: mostly a pool key, sometimes a fully random key.
   task automatic send_random_request();
      logic [31:0] key;
      hmte_pkg::cmd_type cmd;
      cmd = hmte_pkg::cmd_type'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) key = $urandom;
      else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_request(cmd, key, $urandom);
   endtask

   // Extremes of key and value, every command, and each table case: lookup hit
   // and miss, insert and replace onto a present key, a new entry, a full
   // bucket, remove hit and miss, and reuse of a freed way.
   task automatic test_directed();
      send_request(hmte_pkg::CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(hmte_pkg::CMD_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(hmte_pkg::CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000);
      send_request(hmte_pkg::CMD_INSERT, 32'h8000_0000, 32'h0000_0000);
      send_request(hmte_pkg::CMD_LOOKUP, 32'h8000_0000, 32'h1234_5678);
      send_request(hmte_pkg::CMD_REPLACE, 32'h8000_0000, 32'h0000_0000);
      // A hit on a zero value must still report the key as present.
      send_request(hmte_pkg::CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000);
      send_request(hmte_pkg::CMD_REPLACE, 32'h7FFF_FFFF, 32'h0000_0001);
      send_request(hmte_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(hmte_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
      // Keys that differ only above the bucket bits share bucket zero.
      send_request(hmte_pkg::CMD_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
      send_request(hmte_pkg::CMD_REPLACE, 32'h0000_0080, 32'h5A5A_5A5A);
      send_request(hmte_pkg::CMD_INSERT, 32'hFFFF_FF80, 32'h8000_0000);
      send_request(hmte_pkg::CMD_INSERT, 32'h0000_0100, 32'h0000_0002);
      send_request(hmte_pkg::CMD_REPLACE, 32'h0000_0100, 32'h0000_0003);
      send_request(hmte_pkg::CMD_LOOKUP, 32'h0000_0100, 32'h0000_0000);
      send_request(hmte_pkg::CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
      send_request(hmte_pkg::CMD_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);
      // The freed way is the lowest free one and takes the next new key.
      send_request(hmte_pkg::CMD_INSERT, 32'h0000_0100, 32'h0000_0004);
      send_request(hmte_pkg::CMD_LOOKUP, 32'h0000_0100, 32'h0000_0000);
      send_request(hmte_pkg::CMD_LOOKUP, 32'hFFFF_FF80, 32'h0000_0000);
      send_request(hmte_pkg::CMD_REMOVE, 32'h0000_0005, 32'h0000_0000);
      wait_for_replies();
   endtask

   // Random traffic with random gaps on both sides.
   task automatic test_random_mix(int count, int bucket_count);
      refill_key_pool(bucket_count);
      for (int i = 0; i < count; i++) send_random_request();
      wait_for_replies();
   endtask

   // Back-to-back words on both sides, so that every word follows its
   // predecessor directly and the row forwarding path is exercised.
   task automatic test_streaming(int count);
      refill_key_pool(2);
      sender_steady = 1'b1;
      receiver_steady = 1'b1;
      for (int i = 0; i < count; i++) send_random_request();
      wait_for_replies();
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering words, so the block fills up and lowers req_tready.
   task automatic test_backpressure(int count);
      refill_key_pool(3);
      sender_steady = 1'b1;
      hold_off_cycles = 300;
      for (int i = 0; i < count; i++) send_random_request();
      sender_steady = 1'b0;
      wait_for_replies();
   endtask

   // Checks each response word against the oldest predicted reply.
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_replies.size() == 0) begin
            report_mismatch("response word with no request waiting, found_value",
                            rsp_tdata, 32'h0);
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_tuser !== want.outcome)
               report_mismatch("outcome", 32'(rsp_tuser), 32'(want.outcome));
            if (rsp_tdata !== want.found_value)
               report_mismatch("found_value", rsp_tdata, want.found_value);
         end
      end
   end

   // Receiver: a random stall before each word, unless steady, and a long
   // hold-off counted here whenever one is asked for.
   initial begin
      int stall;
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end
         stall = receiver_steady ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock);
         while (!(rsp_tvalid && rsp_tready) && hold_off_cycles == 0);
      end
   end

   // Ends a run that hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      for (int s = 0; s < SLOTS; s++) begin
         map_valid[s] = 1'b0;
         map_key[s] = '0;
         map_value[s] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // The clearing pass after reset simply shows up as a long wait for req_tready.
      test_directed();
      test_random_mix(300, 8);
      test_streaming(150);
      test_backpressure(60);
      test_random_mix(140, 4);
      wait_for_replies();
      repeat (12) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
